### hdl/fpa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fixed-point ALU package
// Operation and status codes, and the saturation helper shared by the ALU.
// ---------------------------------------------------------------------------
package fpa_pkg;

    localparam logic [3:0] FUNC_ADD     = 4'd0;
    localparam logic [3:0] FUNC_SUB     = 4'd1;
    localparam logic [3:0] FUNC_MUL     = 4'd2;
    localparam logic [3:0] FUNC_DIV     = 4'd3;
    localparam logic [3:0] FUNC_GT      = 4'd4;
    localparam logic [3:0] FUNC_LT      = 4'd5;
    localparam logic [3:0] FUNC_GE      = 4'd6;
    localparam logic [3:0] FUNC_LE      = 4'd7;
    localparam logic [3:0] FUNC_EQ      = 4'd8;
    localparam logic [3:0] FUNC_NE      = 4'd9;
    localparam logic [3:0] FUNC_MIN     = 4'd10;
    localparam logic [3:0] FUNC_MAX     = 4'd11;
    localparam logic [3:0] FUNC_INC     = 4'd12;
    localparam logic [3:0] FUNC_DEC     = 4'd13;
    localparam logic [3:0] FUNC_TOINT   = 4'd14;
    localparam logic [3:0] FUNC_FROMINT = 4'd15;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_SAT  = 2'd1;
    localparam logic [1:0] STATUS_DIV0 = 2'd2;

    localparam logic [31:0] MAX32 = 32'h7fff_ffff;
    localparam logic [31:0] MIN32 = 32'h8000_0000;

    typedef struct packed {
        logic [3:0]  func;
        logic [31:0] a;
        logic [31:0] b;
    } item_t;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } sres_t;

    // Applies a sign to a magnitude and clamps to the 32-bit signed range.
    function automatic sres_t clamp_mag(input logic [63:0] mag, input logic neg);
        sres_t r;
        r.sat = 1'b0;
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) begin
                r.value = MIN32;
                r.sat   = 1'b1;
            end else begin
                r.value = 32'd0 - mag[31:0];
            end
        end else begin
            if (mag > 64'h0000_0000_7fff_ffff) begin
                r.value = MAX32;
                r.sat   = 1'b1;
            end else begin
                r.value = mag[31:0];
            end
        end
        return r;
    endfunction

endpackage

### hdl/fpa_div_pipe.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, with a payload carried alongside each item.
// ---------------------------------------------------------------------------
module fpa_div_pipe #(
    parameter int QW = 40,
    parameter int TW = 68
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [QW-1:0] num,
    input  logic [31:0]   den,
    input  logic [TW-1:0] tag_in,
    output logic          out_valid,
    output logic [QW-1:0] quot,
    output logic [31:0]   rem,
    output logic [TW-1:0] tag_out
);

    // Stage k holds its result in entry k of each register array.
    logic          vld_reg [0:QW-1];
    logic [QW-1:0] num_reg [0:QW-1];
    logic [QW-1:0] quo_reg [0:QW-1];
    logic [31:0]   rem_reg [0:QW-1];
    logic [31:0]   den_reg [0:QW-1];
    logic [TW-1:0] tag_reg [0:QW-1];

    // What each stage sees at its input, and its trial subtraction.
    logic [QW-1:0] num_s [0:QW-1];
    logic [QW-1:0] quo_s [0:QW-1];
    logic [31:0]   rem_s [0:QW-1];
    logic [31:0]   den_s [0:QW-1];
    logic [TW-1:0] tag_s [0:QW-1];
    logic [32:0]   trial [0:QW-1];
    logic          take  [0:QW-1];

    always_comb begin
        num_s[0] = num;
        quo_s[0] = '0;
        rem_s[0] = '0;
        den_s[0] = den;
        tag_s[0] = tag_in;
        for (int k = 1; k < QW; k++) begin
            num_s[k] = num_reg[k-1];
            quo_s[k] = quo_reg[k-1];
            rem_s[k] = rem_reg[k-1];
            den_s[k] = den_reg[k-1];
            tag_s[k] = tag_reg[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            trial[k] = {rem_s[k], num_s[k][QW-1]};
            take[k]  = (trial[k] >= {1'b0, den_s[k]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < QW; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < QW; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QW; k++) begin
                num_reg[k] <= {num_s[k][QW-2:0], 1'b0};
                quo_reg[k] <= {quo_s[k][QW-2:0], take[k]};
                rem_reg[k] <= take[k] ? 32'(trial[k] - {1'b0, den_s[k]}) : trial[k][31:0];
                den_reg[k] <= den_s[k];
                tag_reg[k] <= tag_s[k];
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quot      = quo_reg[QW-1];
    assign rem       = rem_reg[QW-1];
    assign tag_out   = tag_reg[QW-1];

endmodule

### hdl/fixed_point_alu.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fixed-point ALU
// Signed 32-bit fixed-point arithmetic, comparison and conversion unit.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Payload (lowest bits first)
//  --------+-----------+--------------------------------------------------
//  s_axis  | in        | func[3:0], operand_a[31:0], operand_b[31:0]
//  m_axis  | out       | value[31:0], flag, status[1:0]
//
//  One transaction may enter in every cycle while s_tready is high. Each
//  transaction passes through the divider, which resolves one quotient
//  bit per stage, and then through the finishing stages. Every other
//  operation travels through the same stages so that results leave in
//  order. Reset (aresetn low at a clock edge) clears only the valid bits.
//  When the result register is full and m_tready is low, the whole
//  pipeline holds and s_tready falls, so nothing is lost or repeated.
//
module fixed_point_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // func[3:0], operand_a[35:4], operand_b[67:36]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // value[31:0], flag[32], status[34:33]
);
    import fpa_pkg::*;

    localparam int QW = 32 + FRAC_BITS;

    // The pipeline advances as one whenever the result register can move.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Input decode: the divider receives |a| scaled by the fraction bits.
    item_t       in_item;
    logic [31:0] in_ma;
    logic [31:0] in_mb;
    assign in_item.func = s_tdata[3:0];
    assign in_item.a    = s_tdata[35:4];
    assign in_item.b    = s_tdata[67:36];
    assign in_ma = in_item.a[31] ? 32'd0 - in_item.a : in_item.a;
    assign in_mb = in_item.b[31] ? 32'd0 - in_item.b : in_item.b;

    logic          d_valid;
    logic [QW-1:0] d_quot;
    logic [31:0]   d_rem;
    logic [67:0]   d_tag;

    fpa_div_pipe #(
        .QW(QW),
        .TW(68)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .num      ({{(QW-32){1'b0}}, in_ma} << FRAC_BITS),
        .den      (in_mb),
        .tag_in   (in_item),
        .out_valid(d_valid),
        .quot     (d_quot),
        .rem      (d_rem),
        .tag_out  (d_tag)
    );

    // First finishing stage: the product, the rounded quotient and every
    // operation that needs neither of them.
    item_t       e_item;
    logic [31:0] e_ma;
    logic [31:0] e_mb;
    logic        e_neg;
    logic [32:0] sum33;
    logic [32:0] dif33;
    logic [32:0] inc33;
    logic [32:0] dec33;
    logic [QW:0] qr;
    sres_t       fi_res;
    logic [31:0] simple_value;
    logic        simple_flag;
    logic        simple_sat;

    assign e_item = d_tag;
    assign e_ma   = e_item.a[31] ? 32'd0 - e_item.a : e_item.a;
    assign e_mb   = e_item.b[31] ? 32'd0 - e_item.b : e_item.b;
    assign e_neg  = e_item.a[31] ^ e_item.b[31];
    assign sum33  = {e_item.a[31], e_item.a} + {e_item.b[31], e_item.b};
    assign dif33  = {e_item.a[31], e_item.a} - {e_item.b[31], e_item.b};
    assign inc33  = {e_item.a[31], e_item.a} + 33'd1;
    assign dec33  = {e_item.a[31], e_item.a} - 33'd1;
    // Round half away from zero: bump when twice the remainder reaches |b|.
    assign qr = {1'b0, d_quot} + {{QW{1'b0}}, ({d_rem, 1'b0} >= {1'b0, e_mb})};
    assign fi_res = clamp_mag(64'(e_ma) << FRAC_BITS, e_item.a[31]);

    always_comb begin
        simple_value = '0;
        simple_flag  = 1'b0;
        simple_sat   = 1'b0;
        case (e_item.func)
            FUNC_ADD: begin
                simple_sat   = sum33[32] != sum33[31];
                simple_value = simple_sat ? (sum33[32] ? MIN32 : MAX32) : sum33[31:0];
            end
            FUNC_SUB: begin
                simple_sat   = dif33[32] != dif33[31];
                simple_value = simple_sat ? (dif33[32] ? MIN32 : MAX32) : dif33[31:0];
            end
            FUNC_INC: begin
                simple_sat   = inc33[32] != inc33[31];
                simple_value = simple_sat ? MAX32 : inc33[31:0];
            end
            FUNC_DEC: begin
                simple_sat   = dec33[32] != dec33[31];
                simple_value = simple_sat ? MIN32 : dec33[31:0];
            end
            FUNC_GT:  simple_flag = $signed(e_item.a) >  $signed(e_item.b);
            FUNC_LT:  simple_flag = $signed(e_item.a) <  $signed(e_item.b);
            FUNC_GE:  simple_flag = $signed(e_item.a) >= $signed(e_item.b);
            FUNC_LE:  simple_flag = $signed(e_item.a) <= $signed(e_item.b);
            FUNC_EQ:  simple_flag = e_item.a == e_item.b;
            FUNC_NE:  simple_flag = e_item.a != e_item.b;
            FUNC_MIN: simple_value = ($signed(e_item.a) < $signed(e_item.b)) ? e_item.a
                                                                             : e_item.b;
            FUNC_MAX: simple_value = ($signed(e_item.a) > $signed(e_item.b)) ? e_item.a
                                                                             : e_item.b;
            FUNC_TOINT: simple_value = 32'($signed(e_item.a) >>> FRAC_BITS);
            FUNC_FROMINT: begin
                simple_value = fi_res.value;
                simple_sat   = fi_res.sat;
            end
            default: begin
                simple_value = '0;
            end
        endcase
    end

    logic        f_valid_reg;
    logic [3:0]  f_func_reg;
    logic        f_neg_reg;
    logic        f_div0_reg;
    logic [63:0] f_prod_reg;
    logic [QW:0] f_qr_reg;
    logic [31:0] f_value_reg;
    logic        f_flag_reg;
    logic        f_sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_func_reg  <= e_item.func;
            f_neg_reg   <= e_neg;
            f_div0_reg  <= (e_mb == 32'd0);
            f_prod_reg  <= 64'(e_ma) * 64'(e_mb);
            f_qr_reg    <= qr;
            f_value_reg <= simple_value;
            f_flag_reg  <= simple_flag;
            f_sat_reg   <= simple_sat;
        end
    end

    // Second finishing stage: round the product, clamp and select.
    logic [63:0] mul_mag;
    sres_t       mul_res;
    sres_t       div_res;
    logic [31:0] value_next;
    logic        flag_next;
    logic [1:0]  status_next;

    assign mul_mag = (f_prod_reg + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign mul_res = clamp_mag(mul_mag, f_neg_reg);
    assign div_res = clamp_mag(64'(f_qr_reg), f_neg_reg);

    always_comb begin
        value_next  = f_value_reg;
        flag_next   = f_flag_reg;
        status_next = f_sat_reg ? STATUS_SAT : STATUS_OK;
        case (f_func_reg)
            FUNC_MUL: begin
                value_next  = mul_res.value;
                status_next = mul_res.sat ? STATUS_SAT : STATUS_OK;
            end
            FUNC_DIV: begin
                if (f_div0_reg) begin
                    value_next  = '0;
                    status_next = STATUS_DIV0;
                end else begin
                    value_next  = div_res.value;
                    status_next = div_res.sat ? STATUS_SAT : STATUS_OK;
                end
            end
            default: begin
                value_next = f_value_reg;
            end
        endcase
    end

    logic        m_valid_reg;
    logic [31:0] m_value_reg;
    logic        m_flag_reg;
    logic [1:0]  m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_value_reg  <= value_next;
            m_flag_reg   <= flag_next;
            m_status_reg <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_status_reg, m_flag_reg, m_value_reg};

endmodule

### tb/fixed_point_alu_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fixed-point ALU testbench
// Drives directed and random operations into the ALU stream input, predicts
// each result with an exact integer model and checks every result in order.
// ---------------------------------------------------------------------------
module fixed_point_alu_test;
    import fpa_pkg::*;

    localparam int FRAC = 8;

    typedef struct packed {
        logic [31:0] value;
        logic        flag;
        logic [1:0]  status;
    } alu_result_t;

    // Keeps the results still owed by the ALU, oldest first, and compares
    // each returned transaction against the oldest one.
    class alu_scoreboard;
        alu_result_t owed[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // Clamps a 64-bit signed value into 32 bits, flagging saturation.
        static function void clamp(input longint v, inout alu_result_t r);
            if (v > 64'sd2147483647) begin
                r.value  = MAX32;
                r.status = STATUS_SAT;
            end else if (v < -64'sd2147483648) begin
                r.value  = MIN32;
                r.status = STATUS_SAT;
            end else begin
                r.value = v[31:0];
            end
        endfunction

        // Works out the exact result of one operation.
        static function alu_result_t compute(input logic [3:0] func,
                                             input logic [31:0] ra,
                                             input logic [31:0] rb);
            alu_result_t r;
            longint      a;
            longint      b;
            longint      ma;
            longint      mb;
            longint      q;
            logic        neg;
            a   = longint'($signed(ra));
            b   = longint'($signed(rb));
            ma  = a < 0 ? -a : a;
            mb  = b < 0 ? -b : b;
            neg = (a < 0) != (b < 0);
            r   = '0;
            case (func)
                FUNC_ADD: clamp(a + b, r);
                FUNC_SUB: clamp(a - b, r);
                FUNC_MUL: begin
                    // Magnitudes at most 2^31 each, so the product fits in 63 bits.
                    q = (ma * mb + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
                    clamp(neg ? -q : q, r);
                end
                FUNC_DIV: begin
                    if (mb == 0) begin
                        r.status = STATUS_DIV0;
                    end else begin
                        q = ((ma <<< FRAC) * 2 + mb) / (mb * 2);
                        clamp(neg ? -q : q, r);
                    end
                end
                FUNC_GT: r.flag = a > b;
                FUNC_LT: r.flag = a < b;
                FUNC_GE: r.flag = a >= b;
                FUNC_LE: r.flag = a <= b;
                FUNC_EQ: r.flag = a == b;
                FUNC_NE: r.flag = a != b;
                FUNC_MIN: r.value = (a < b) ? ra : rb;
                FUNC_MAX: r.value = (a > b) ? ra : rb;
                FUNC_INC: clamp(a + 1, r);
                FUNC_DEC: clamp(a - 1, r);
                FUNC_TOINT: r.value = $signed(ra) >>> FRAC;
                default: clamp(a <<< FRAC, r);
            endcase
            return r;
        endfunction

        function void note_operation(input logic [71:0] tdata);
            owed.push_back(compute(tdata[3:0], tdata[35:4], tdata[67:36]));
        endfunction

        function void check_result(input logic [39:0] tdata);
            alu_result_t got;
            alu_result_t exp;
            got.value  = tdata[31:0];
            got.flag   = tdata[32];
            got.status = tdata[34:33];
            if (owed.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = owed.pop_front();
            if (got.value !== exp.value) begin
                $display("%0t: value expected %h actual %h", $time, exp.value, got.value);
                errors++;
            end
            if (got.flag !== exp.flag) begin
                $display("%0t: flag expected %b actual %b", $time, exp.flag, got.flag);
                errors++;
            end
            if (got.status !== exp.status) begin
                $display("%0t: status expected %0d actual %0d", $time, exp.status,
                         got.status);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    // When set, neither side idles: a long stretch at full rate.
    logic        no_idle = 1'b0;

    alu_scoreboard results = new();

    fixed_point_alu #(.FRAC_BITS(FRAC)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #2 aclk = ~aclk;

    // Accepted transactions are noted and checked at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            results.note_operation(s_tdata);
        end
        if (aresetn && m_tvalid && m_tready) begin
            results.check_result(m_tdata);
        end
    end

    // The receiver drops m_tready at random with a probability of seven percent, unless no_idle is set.
    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= 7);
    end

    // Sends one operation, with a random gap before it, and holds it until
    // the ALU takes it. Valid stays high between back-to-back transactions.
    task automatic send_operation(input logic [3:0] func, input logic [31:0] a,
                                  input logic [31:0] b);
        while (!no_idle && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, b, a, func};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Picks an operand leaning towards the edges of the range.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return MAX32 - $urandom_range(3);
            1: return MIN32 + $urandom_range(3);
            2: return $urandom_range(3) - 1;
            3: return $urandom_range(65535) - 32768;
            4: return $urandom_range(16777215) - 8388608;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [31:0] a;
        logic [31:0] b;
        int          drain;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part: every operation on range extremes, plus the special
        // cases of division by zero, equal operands and rounding halfway.
        for (int f = 0; f < 16; f++) begin
            send_operation(f[3:0], MAX32, MIN32);
        end
        send_operation(FUNC_DIV, 32'd5, 32'd0);
        send_operation(FUNC_MIN, 32'd7, 32'd7);
        send_operation(FUNC_MAX, MIN32, MIN32);
        send_operation(FUNC_EQ, MIN32, MIN32);
        send_operation(FUNC_MUL, 32'h0000_0180, 32'hffff_ff80);
        send_operation(FUNC_DIV, 32'h0000_0001, 32'h0000_0200);
        send_operation(FUNC_TOINT, 32'hffff_ffff, 32'd0);
        send_operation(FUNC_FROMINT, 32'h007f_ffff, 32'd0);
        send_operation(FUNC_MUL, MIN32, MIN32);

        // Random part, with a run of a few hundred at full rate in the middle.
        for (int n = 0; n < 900; n++) begin
            no_idle = (n >= 300 && n < 500);
            a = ($urandom_range(3) == 0) ? $urandom() : pick_operand();
            b = ($urandom_range(3) == 0) ? $urandom() : pick_operand();
            send_operation(4'($urandom_range(15)), a, b);
        end
        no_idle  = 1'b0;
        s_tvalid <= 1'b0;

        while (results.owed.size() != 0) @(posedge aclk);
        drain = 0;
        while (drain < 100) begin
            @(posedge aclk);
            drain++;
        end
        if (results.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
